// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the transfer payload structs, the operation codes and the default geometry.
// No dependencies.
package tcw_pkg;

    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;
    localparam int unsigned START_LINE  = 19;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] ATTR_RESET   = 8'h02;

    typedef logic [1:0]  t_kind;
    typedef logic [15:0] t_cell;

    localparam t_kind KIND_PRINT    = 2'd0;
    localparam t_kind KIND_PRINT_AT = 2'd1;
    localparam t_kind KIND_READ     = 2'd2;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
        logic [6:0] col;
        logic [4:0] row;
    } t_item;

    typedef struct packed {
        t_cell      cell_value;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } t_result;

endpackage

// File: sv/tcw_cell_ram.sv
// Character cell memory: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell type.
module tcw_cell_ram #(
    parameter int unsigned DEPTH = 2000,
    parameter int unsigned AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  tcw_pkg::t_cell i_wdata,
    input  logic [AW-1:0] i_raddr,
    output tcw_pkg::t_cell o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tcw_addr_unit.sv
// Cell address unit: turns a row and column into a linear cell address.
// Depends on tcw_pkg only through the parameter defaults of its user.
module tcw_addr_unit #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic [$clog2(ROWS)-1:0]           i_row,
    input  logic [$clog2(COLUMNS)-1:0]        i_col,
    output logic [$clog2(COLUMNS*ROWS)-1:0]   o_addr
);
    localparam int unsigned AW = $clog2(COLUMNS * ROWS);

    // Multiply by a constant row pitch, then add the column offset.
    assign o_addr = AW'(AW'(i_row) * AW'(COLUMNS) + AW'(i_col));

endmodule

// File: sv/text_console_writer.sv
// Text console writer: a print transfer goes through the execute state to the done strobe,
// a cell read adds the read state, and a print that scrolls adds the scroll and fill states.
// One transfer is taken at a time, only while idle; busy stays high for the whole of a scroll.
// After reset the cell store is cleared one cell per cycle (all COLUMNS*ROWS cells, 2000 by
// default) while busy is high; attribute writes are taken during that pass.
// Results are strobed for one cycle on o_done and cannot be stalled by the receiver.
module text_console_writer #(
    parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_done,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    // Geometry derived from the parameters.
    localparam int unsigned CELLS      = COLUMNS * ROWS;
    localparam int unsigned COPY_CELLS = COLUMNS * (ROWS - 1);
    localparam int unsigned CW         = $clog2(COLUMNS);
    localparam int unsigned RW         = $clog2(ROWS);
    localparam int unsigned AW         = $clog2(CELLS);
    localparam int unsigned START_ROW  = (START_LINE >= ROWS) ? (ROWS - 1) : START_LINE;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;

    logic [2:0]    r_state,   n_state;
    logic [AW-1:0] r_cnt,     n_cnt;
    logic          r_emit,    n_emit;
    logic          r_wpend,   n_wpend;
    logic [AW-1:0] r_waddr,   n_waddr;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [7:0]    r_attr;
    logic          r_done,    n_done;
    t_result       r_result,  n_result;

    // The item being worked on, with its position already resolved.
    t_kind         r_kind;
    logic [7:0]    r_code;
    logic [CW-1:0] r_wcol;
    logic [RW-1:0] r_wrow;

    logic          accept;
    logic [CW-1:0] sat_col;
    logic [RW-1:0] sat_row;
    logic [AW-1:0] cell_addr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_cell         ram_wdata;
    t_cell         ram_rdata;

    logic          is_nl;
    logic          is_print;
    logic [CW:0]   col_inc;
    logic          wrap;
    logic          at_bottom;
    logic          line_feed;
    logic          need_scroll;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Out-of-range positions saturate to the last column or row.
    assign sat_col = (32'(i_item.col) >= 32'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(i_item.col);
    assign sat_row = (32'(i_item.row) >= 32'(ROWS))    ? RW'(ROWS - 1)    : RW'(i_item.row);

    tcw_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .i_row  (r_wrow),
        .i_col  (r_wcol),
        .o_addr (cell_addr)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decisions for the item in the execute state.
    assign is_nl       = (r_code == NEWLINE_CODE);
    assign is_print    = (r_kind == KIND_PRINT) || (r_kind == KIND_PRINT_AT);
    assign col_inc     = {1'b0, r_wcol} + (CW + 1)'(1);
    assign wrap        = (col_inc == (CW + 1)'(COLUMNS));
    assign at_bottom   = (r_wrow == RW'(ROWS - 1));
    assign line_feed   = is_print && (is_nl || wrap);
    assign need_scroll = line_feed && at_bottom;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_emit    = r_emit;
        n_wpend   = r_wpend;
        n_waddr   = r_waddr;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = '0;
        ram_raddr = cell_addr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // A printable character is written in this cycle; a newline writes nothing.
                if (is_print && !is_nl) begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_attr, r_code};
                end
                // Only a print at the cursor moves the cursor; a positioned print leaves it where it was.
                if (r_kind == KIND_PRINT) begin
                    if (line_feed) begin
                        n_cur_col = '0;
                        n_cur_row = at_bottom ? r_wrow : (r_wrow + RW'(1));
                    end else begin
                        n_cur_col = CW'(col_inc);
                    end
                end
                if (need_scroll) begin
                    n_state = S_SCROLL;
                    n_cnt   = '0;
                    n_wpend = 1'b0;
                end else if (r_kind == KIND_READ) begin
                    n_state = S_READ;
                end else begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{cell_value: '0,
                                 cursor_col: 7'(n_cur_col),
                                 cursor_row: 5'(n_cur_row),
                                 scrolled:   1'b0};
                end
            end
            S_READ: begin
                // Read data issued in the execute state is now out of the memory.
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_result = '{cell_value: ram_rdata,
                             cursor_col: 7'(r_cur_col),
                             cursor_row: 5'(r_cur_row),
                             scrolled:   1'b0};
            end
            S_SCROLL: begin
                // Each cycle reads the cell one row below and writes the cell read in the
                // previous cycle; the destination always trails the source.
                ram_we    = r_wpend;
                ram_waddr = r_waddr;
                ram_wdata = ram_rdata;
                ram_raddr = r_cnt + AW'(COLUMNS);
                if (r_cnt == AW'(COPY_CELLS)) begin
                    n_wpend = 1'b0;
                    n_emit  = 1'b1;
                    n_state = S_FILL;
                end else begin
                    n_wpend = 1'b1;
                    n_waddr = r_cnt;
                    n_cnt   = r_cnt + AW'(1);
                end
            end
            S_FILL: begin
                // Zero fill: the bottom row after a scroll, or the whole store after reset.
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_emit  = 1'b0;
                    if (r_emit) begin
                        n_done   = 1'b1;
                        n_result = '{cell_value: '0,
                                     cursor_col: 7'(r_cur_col),
                                     cursor_row: 5'(r_cur_row),
                                     scrolled:   1'b1};
                    end
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_cnt     <= '0;
            r_emit    <= 1'b0;
            r_wpend   <= 1'b0;
            r_cur_col <= '0;
            r_cur_row <= RW'(START_ROW);
            r_attr    <= ATTR_RESET;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_emit    <= n_emit;
            r_wpend   <= n_wpend;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_done    <= n_done;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_waddr  <= n_waddr;
        r_result <= n_result;
        if (accept) begin
            r_kind <= i_item.kind;
            r_code <= i_item.char_code;
            if (i_item.kind == KIND_PRINT) begin
                r_wcol <= r_cur_col;
                r_wrow <= r_cur_row;
            end else begin
                r_wcol <= sat_col;
                r_wrow <= sat_row;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_done)
        else $error("result strobed in the cycle right after a transfer was accepted");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobed without the block having been busy");

    a_scroll_from_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.scrolled) |-> ($past(r_state) == S_FILL))
        else $error("scroll reported before the bottom row fill finished");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row <= RW'(ROWS - 1)) && (32'(r_cur_col) < 32'(COLUMNS)))
        else $error("cursor outside the screen");

endmodule
